/* design/dwmb_pkg.sv */
// dwmb_pkg: shared widths, register indexes, reset values and the pixel result type
// for the depth window mask and bounding box block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dwmb_pkg;

    localparam int DEPTH_W    = 16;
    localparam int GAIN_W     = 24;
    localparam int FSIZE_W    = 11;
    localparam int LEVEL_W    = 8;
    localparam int BOX_POS_W  = 10;
    localparam int BOX_SIZE_W = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    // wide enough for any counter, frame size and box span up to 4096
    localparam int CALC_W     = 13;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST    = 16'd200;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST    = 16'd1000;
    localparam logic [GAIN_W-1:0]  DISPLAY_GAIN_RST = 24'd20889;
    localparam logic [FSIZE_W-1:0] FRAME_WIDTH_RST  = 11'd320;
    localparam logic [FSIZE_W-1:0] FRAME_HEIGHT_RST = 11'd240;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DEPTH    = 3'd0,
        CFG_MAX_DEPTH    = 3'd1,
        CFG_DISPLAY_GAIN = 3'd2,
        CFG_FRAME_WIDTH  = 3'd3,
        CFG_FRAME_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic               hit;
        logic [LEVEL_W-1:0] level;
    } t_pix_res;

endpackage

`default_nettype wire

/* design/dwmb_pixel_math.sv */
// dwmb_pixel_math: window test and saturated display level for one pixel
// depends on dwmb_pkg
`timescale 1ns / 1ps
`default_nettype none

module dwmb_pixel_math (
    input  wire logic [dwmb_pkg::DEPTH_W-1:0] i_depth,
    input  wire logic [dwmb_pkg::DEPTH_W-1:0] i_min_depth,
    input  wire logic [dwmb_pkg::DEPTH_W-1:0] i_max_depth,
    input  wire logic [dwmb_pkg::GAIN_W-1:0]  i_gain,
    output dwmb_pkg::t_pix_res                o_res
);

    localparam int PROD_W = dwmb_pkg::DEPTH_W + dwmb_pkg::GAIN_W;
    localparam int FRAC_W = 16;

    logic                             hit;
    logic [dwmb_pkg::DEPTH_W-1:0]     diff;
    logic [PROD_W-1:0]                prod;
    logic [PROD_W-FRAC_W-1:0]         scaled;
    logic [dwmb_pkg::LEVEL_W-1:0]     level;

    always_comb begin
        hit    = (i_depth >= i_min_depth) && (i_depth <= i_max_depth);
        diff   = i_depth - i_min_depth;
        prod   = PROD_W'(diff) * PROD_W'(i_gain);
        scaled = prod[PROD_W-1:FRAC_W];
        // saturate at full scale
        if (|scaled[PROD_W-FRAC_W-1:dwmb_pkg::LEVEL_W]) begin
            level = '1;
        end else begin
            level = scaled[dwmb_pkg::LEVEL_W-1:0];
        end
        o_res.hit   = hit;
        o_res.level = hit ? level : '0;
    end

endmodule

`default_nettype wire

/* design/depth_window_mask_bbox.sv */
// depth_window_mask_bbox: depth window mask, display level and per-frame bounding box
// depends on dwmb_pkg and dwmb_pixel_math
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake                    | payload
// ----------+------------------------------+---------------------------------------------
// pixel in  | i_in_valid / o_in_ready      | i_depth_mm
// result    | o_out_valid / i_out_ready    | o_in_window o_display_level o_frame_end
//           |                              | o_box_found o_box_left o_box_top
//           |                              | o_box_width o_box_height
// config    | i_cfg_we (no wait)           | i_cfg_idx i_cfg_data
//
// one pixel per clock sustained while i_out_ready stays high; input register, then result register
// the result register stage holds the only multiplier (16 x 24 display scaling)
// a stalled result keeps its register; the input register still takes one more request
// synchronous active-low reset clears valid bits, counters and box state, and loads the config reset values

module depth_window_mask_bbox #(
    parameter int MAX_WIDTH  = dwmb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dwmb_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config write port
    input  wire logic                               i_cfg_we,
    input  wire logic [dwmb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [dwmb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // pixel requests
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [dwmb_pkg::DEPTH_W-1:0]       i_depth_mm,
    // results
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_in_window,
    output logic [dwmb_pkg::LEVEL_W-1:0]            o_display_level,
    output logic                                    o_frame_end,
    output logic                                    o_box_found,
    output logic [dwmb_pkg::BOX_POS_W-1:0]          o_box_left,
    output logic [dwmb_pkg::BOX_POS_W-1:0]          o_box_top,
    output logic [dwmb_pkg::BOX_SIZE_W-1:0]         o_box_width,
    output logic [dwmb_pkg::BOX_SIZE_W-1:0]         o_box_height
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int XW = dwmb_pkg::CALC_W;
    localparam logic [XW-1:0] MAX_W_X = XW'(MAX_WIDTH);
    localparam logic [XW-1:0] MAX_H_X = XW'(MAX_HEIGHT);

    // config registers
    logic [dwmb_pkg::DEPTH_W-1:0] r_min_depth;
    logic [dwmb_pkg::DEPTH_W-1:0] r_max_depth;
    logic [dwmb_pkg::GAIN_W-1:0]  r_gain;
    logic [dwmb_pkg::FSIZE_W-1:0] r_frame_width;
    logic [dwmb_pkg::FSIZE_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_depth    <= dwmb_pkg::MIN_DEPTH_RST;
            r_max_depth    <= dwmb_pkg::MAX_DEPTH_RST;
            r_gain         <= dwmb_pkg::DISPLAY_GAIN_RST;
            r_frame_width  <= dwmb_pkg::FRAME_WIDTH_RST;
            r_frame_height <= dwmb_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dwmb_pkg::CFG_MIN_DEPTH: begin
                    r_min_depth <= i_cfg_data[dwmb_pkg::DEPTH_W-1:0];
                end
                dwmb_pkg::CFG_MAX_DEPTH: begin
                    r_max_depth <= i_cfg_data[dwmb_pkg::DEPTH_W-1:0];
                end
                dwmb_pkg::CFG_DISPLAY_GAIN: begin
                    r_gain <= i_cfg_data[dwmb_pkg::GAIN_W-1:0];
                end
                dwmb_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[dwmb_pkg::FSIZE_W-1:0];
                end
                dwmb_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[dwmb_pkg::FSIZE_W-1:0];
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // pipeline control: input register feeds result register
    logic                         r_in_valid;
    logic [dwmb_pkg::DEPTH_W-1:0] r_depth;
    logic                         advance;

    assign advance    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_depth <= i_depth_mm;
        end
    end

    // window test and display level
    dwmb_pkg::t_pix_res pix;

    dwmb_pixel_math u_math (
        .i_depth     (r_depth),
        .i_min_depth (r_min_depth),
        .i_max_depth (r_max_depth),
        .i_gain      (r_gain),
        .o_res       (pix)
    );

    // raster position and box state
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_left, n_left, r_right, n_right;
    logic [RW-1:0] r_top, n_top, r_bottom, n_bottom;
    logic          r_any, n_any;

    logic [XW-1:0] fw_x, fh_x, w_x, h_x;
    logic          row_end, frame_end;
    logic [XW-1:0] span_w, span_h;

    always_comb begin
        // frame size clamped to [1, max]
        fw_x = XW'(r_frame_width);
        fh_x = XW'(r_frame_height);
        priority if (fw_x == '0)    w_x = XW'(1);
        else if (fw_x > MAX_W_X)    w_x = MAX_W_X;
        else                        w_x = fw_x;
        priority if (fh_x == '0)    h_x = XW'(1);
        else if (fh_x > MAX_H_X)    h_x = MAX_H_X;
        else                        h_x = fh_x;

        row_end   = XW'(r_col) >= (w_x - XW'(1));
        frame_end = row_end && (XW'(r_row) >= (h_x - XW'(1)));

        // box including the current pixel; first hit takes the position outright
        n_left   = r_left;
        n_right  = r_right;
        n_top    = r_top;
        n_bottom = r_bottom;
        n_any    = r_any;
        if (pix.hit) begin
            if (!r_any || (r_col < r_left))   n_left   = r_col;
            if (!r_any || (r_col > r_right))  n_right  = r_col;
            if (!r_any || (r_row < r_top))    n_top    = r_row;
            if (!r_any || (r_row > r_bottom)) n_bottom = r_row;
            n_any = 1'b1;
        end

        span_w = XW'(n_right) - XW'(n_left) + XW'(1);
        span_h = XW'(n_bottom) - XW'(n_top) + XW'(1);

        // raster step
        priority if (frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if (row_end) begin
            n_col = '0;
            n_row = r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= '1;
            r_right  <= '0;
            r_top    <= '1;
            r_bottom <= '0;
            r_any    <= 1'b0;
        end else if (advance) begin
            r_col <= n_col;
            r_row <= n_row;
            if (frame_end) begin
                // new frame starts with an empty box
                r_left   <= '1;
                r_right  <= '0;
                r_top    <= '1;
                r_bottom <= '0;
                r_any    <= 1'b0;
            end else begin
                r_left   <= n_left;
                r_right  <= n_right;
                r_top    <= n_top;
                r_bottom <= n_bottom;
                r_any    <= n_any;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (advance) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_in_window     <= pix.hit;
            o_display_level <= pix.level;
            o_frame_end     <= frame_end;
            // box fields only on the last pixel of a frame that had a hit
            if (frame_end && n_any) begin
                o_box_found  <= 1'b1;
                o_box_left   <= dwmb_pkg::BOX_POS_W'(n_left);
                o_box_top    <= dwmb_pkg::BOX_POS_W'(n_top);
                o_box_width  <= span_w[dwmb_pkg::BOX_SIZE_W-1:0];
                o_box_height <= span_h[dwmb_pkg::BOX_SIZE_W-1:0];
            end else begin
                o_box_found  <= 1'b0;
                o_box_left   <= '0;
                o_box_top    <= '0;
                o_box_width  <= '0;
                o_box_height <= '0;
            end
        end
    end

endmodule

`default_nettype wire

/* design/dwmb_checker.sv */
// dwmb_checker: port-level checks on the depth window mask and bounding box block
// bound to depth_window_mask_bbox; depends on dwmb_pkg
`timescale 1ns / 1ps
`default_nettype none

module dwmb_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic                               o_in_window,
    input  wire logic [dwmb_pkg::LEVEL_W-1:0]       o_display_level,
    input  wire logic                               o_frame_end,
    input  wire logic                               o_box_found,
    input  wire logic [dwmb_pkg::BOX_SIZE_W-1:0]    o_box_width,
    input  wire logic [dwmb_pkg::BOX_SIZE_W-1:0]    o_box_height
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // level is zero outside the window
    a_level_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_window |-> o_display_level == '0)
        else $error("display level outside window");

    // box only reported at frame end
    a_box_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_end |-> !o_box_found && o_box_width == '0
            && o_box_height == '0)
        else $error("box fields outside frame end");

    // a found box is never empty
    a_box_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_box_found |-> o_box_width != '0 && o_box_height != '0)
        else $error("found box with zero size");

    // stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_display_level)
            && $stable(o_frame_end))
        else $error("stalled result changed");

endmodule

bind depth_window_mask_bbox dwmb_checker u_dwmb_checker (.*);

`default_nettype wire

/* verif/tb_depth_window_mask_bbox.sv */
// tb_depth_window_mask_bbox: self-checking testbench for the depth window mask and box block
// depends on dwmb_pkg and depth_window_mask_bbox; predicts every pixel result in step with requests
`timescale 1ns / 1ps

module tb_depth_window_mask_bbox;

    localparam int PERIOD         = 12;
    localparam int RST_CYCLES     = 7;
    // two register stages inside, with spare margin on top
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMEOUT_CYCLES = 200000;

    localparam int DEPTH_W        = dwmb_pkg::DEPTH_W;
    localparam int GAIN_W         = dwmb_pkg::GAIN_W;
    localparam int FSIZE_W        = dwmb_pkg::FSIZE_W;
    localparam int LEVEL_W        = dwmb_pkg::LEVEL_W;
    localparam int BOX_POS_W      = dwmb_pkg::BOX_POS_W;
    localparam int BOX_SIZE_W     = dwmb_pkg::BOX_SIZE_W;
    localparam int CFG_DATA_W     = dwmb_pkg::CFG_DATA_W;
    localparam int MAX_WIDTH_DEF  = dwmb_pkg::MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT_DEF = dwmb_pkg::MAX_HEIGHT_DEF;

    // one pixel result as the block presents it
    typedef struct packed {
        logic                  in_window;
        logic [LEVEL_W-1:0]    display_level;
        logic                  frame_end;
        logic                  box_found;
        logic [BOX_POS_W-1:0]  box_left;
        logic [BOX_POS_W-1:0]  box_top;
        logic [BOX_SIZE_W-1:0] box_width;
        logic [BOX_SIZE_W-1:0] box_height;
    } t_pixel_result;

    // clock, reset and block ports
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    dwmb_pkg::t_cfg_idx    cfg_idx  = dwmb_pkg::CFG_MIN_DEPTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [DEPTH_W-1:0]    depth_mm = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  in_window;
    logic [LEVEL_W-1:0]    display_level;
    logic                  frame_end;
    logic                  box_found;
    logic [BOX_POS_W-1:0]  box_left;
    logic [BOX_POS_W-1:0]  box_top;
    logic [BOX_SIZE_W-1:0] box_width;
    logic [BOX_SIZE_W-1:0] box_height;

    // pixels waiting to be offered, and results owed by the block
    logic [DEPTH_W-1:0]    pending_pixels[$];
    t_pixel_result         pixel_results_due[$];
    int                    pixels_queued   = 0;
    int                    pixels_accepted = 0;
    logic                  in_taken        = 1'b0;
    int                    error_count     = 0;

    // idling knobs, percent of cycles
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    // long receiver hold-off, asked for by bumping hold_reqs
    int                    hold_reqs  = 0;
    int                    hold_taken = 0;
    int                    hold_left  = 0;

    // shadow of the config registers
    logic [DEPTH_W-1:0]    win_min;
    logic [DEPTH_W-1:0]    win_max;
    logic [GAIN_W-1:0]     win_gain;
    logic [FSIZE_W-1:0]    win_width;
    logic [FSIZE_W-1:0]    win_height;

    // shadow of the raster position and box tracking, one bit wider than the block
    // so that the all-ones start value lies above every column and row
    logic [FSIZE_W-1:0]    col_cnt;
    logic [FSIZE_W-1:0]    row_cnt;
    logic [FSIZE_W-1:0]    left_edge;
    logic [FSIZE_W-1:0]    right_edge;
    logic [FSIZE_W-1:0]    top_edge;
    logic [FSIZE_W-1:0]    bottom_edge;
    logic                  any_seen;

    depth_window_mask_bbox dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_depth_mm      (depth_mm),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_in_window     (in_window),
        .o_display_level (display_level),
        .o_frame_end     (frame_end),
        .o_box_found     (box_found),
        .o_box_left      (box_left),
        .o_box_top       (box_top),
        .o_box_width     (box_width),
        .o_box_height    (box_height)
    );

    always #(PERIOD / 2) clk = ~clk;

    // back to the top-left corner with an empty box
    function automatic void clear_box();
        col_cnt     = '0;
        row_cnt     = '0;
        left_edge   = '1;
        right_edge  = '0;
        top_edge    = '1;
        bottom_edge = '0;
        any_seen    = 1'b0;
    endfunction

    // zero reads as one, anything past the maximum reads as the maximum
    function automatic logic [FSIZE_W-1:0] clamp_size(input logic [FSIZE_W-1:0] v, input int lim);
        if (v == 0)
            return FSIZE_W'(1);
        if (v > lim)
            return FSIZE_W'(lim);
        return v;
    endfunction

    // mask bit, display level and box report for one accepted pixel; advances the raster
    function automatic t_pixel_result predict_pixel(input logic [DEPTH_W-1:0] depth);
        logic [FSIZE_W-1:0] w;
        logic [FSIZE_W-1:0] h;
        logic               in_win;
        logic               row_end;
        logic               last;
        logic [39:0]        scaled;
        t_pixel_result      r;
        w = clamp_size(win_width, MAX_WIDTH_DEF);
        h = clamp_size(win_height, MAX_HEIGHT_DEF);
        r = '0;
        in_win = (depth >= win_min) && (depth <= win_max);
        // a counter already past a shrunken size ends the row or frame at once
        row_end = col_cnt >= w - FSIZE_W'(1);
        last = row_end && (row_cnt >= h - FSIZE_W'(1));
        r.in_window = in_win;
        r.frame_end = last;
        if (in_win) begin
            scaled = (40'(depth - win_min) * 40'(win_gain)) >> 16;
            r.display_level = (scaled > 255) ? 8'hff : scaled[7:0];
            if (col_cnt < left_edge)
                left_edge = col_cnt;
            if (col_cnt > right_edge)
                right_edge = col_cnt;
            if (row_cnt < top_edge)
                top_edge = row_cnt;
            if (row_cnt > bottom_edge)
                bottom_edge = row_cnt;
            any_seen = 1'b1;
        end
        if (last) begin
            // box fields stay zero when nothing of the frame fell in the window
            if (any_seen) begin
                r.box_found  = 1'b1;
                r.box_left   = left_edge[BOX_POS_W-1:0];
                r.box_top    = top_edge[BOX_POS_W-1:0];
                r.box_width  = BOX_SIZE_W'(right_edge - left_edge + FSIZE_W'(1));
                r.box_height = BOX_SIZE_W'(bottom_edge - top_edge + FSIZE_W'(1));
            end
            clear_box();
        end else if (row_end) begin
            col_cnt = '0;
            row_cnt = row_cnt + FSIZE_W'(1);
        end else begin
            col_cnt = col_cnt + FSIZE_W'(1);
        end
        return r;
    endfunction

    // depth near the window: inside it, on or next to a bound, or anywhere
    function automatic logic [DEPTH_W-1:0] pick_depth();
        logic [DEPTH_W-1:0] d;
        case ($urandom_range(3))
            0: d = (win_min <= win_max) ? DEPTH_W'($urandom_range(win_min, win_max))
                                        : DEPTH_W'($urandom);
            1: begin
                case ($urandom_range(3))
                    0:       d = win_min - DEPTH_W'(1);
                    1:       d = win_min;
                    2:       d = win_max;
                    default: d = win_max + DEPTH_W'(1);
                endcase
            end
            default: d = DEPTH_W'($urandom);
        endcase
        return d;
    endfunction

    function automatic void push_pixel(input logic [DEPTH_W-1:0] d);
        pending_pixels = {pending_pixels, d};
        pixels_queued++;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // one register write, shadow updated alongside; only called while the block is idle
    task automatic write_reg(input dwmb_pkg::t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            dwmb_pkg::CFG_MIN_DEPTH:    win_min    = value[DEPTH_W-1:0];
            dwmb_pkg::CFG_MAX_DEPTH:    win_max    = value[DEPTH_W-1:0];
            dwmb_pkg::CFG_DISPLAY_GAIN: win_gain   = value[GAIN_W-1:0];
            dwmb_pkg::CFG_FRAME_WIDTH:  win_width  = value[FSIZE_W-1:0];
            dwmb_pkg::CFG_FRAME_HEIGHT: win_height = value[FSIZE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // every request accepted, every result back, then the pipeline's own latency
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pixels_accepted != pixels_queued || pixel_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // knobs change just after a rising edge, away from the falling-edge drivers
    task automatic set_idling(input int send_pct, input int stall_pct);
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // pixel request driver: payload changes only on the falling edge after acceptance
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                depth_mm <= pending_pixels.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_reqs) begin
            hold_taken <= hold_reqs;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: check the result first, then predict the pixel taken at the same edge
    always @(posedge clk) begin
        t_pixel_result got;
        t_pixel_result want;
        in_taken <= in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got = '{in_window, display_level, frame_end, box_found,
                        box_left, box_top, box_width, box_height};
                if (pixel_results_due.size() == 0) begin
                    $display("%0t: result %h arrived with no pixel pending", $time, got);
                    error_count++;
                end else begin
                    want = pixel_results_due.pop_front();
                    check_field("in_window", 32'(want.in_window), 32'(got.in_window));
                    check_field("display_level", 32'(want.display_level),
                                32'(got.display_level));
                    check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
                    check_field("box_found", 32'(want.box_found), 32'(got.box_found));
                    check_field("box_left", 32'(want.box_left), 32'(got.box_left));
                    check_field("box_top", 32'(want.box_top), 32'(got.box_top));
                    check_field("box_width", 32'(want.box_width), 32'(got.box_width));
                    check_field("box_height", 32'(want.box_height), 32'(got.box_height));
                end
            end
            if (in_valid && in_ready) begin
                want = predict_pixel(depth_mm);
                pixel_results_due = {pixel_results_due, want};
                pixels_accepted++;
            end
        end
    end

    // stimulus sequence
    initial begin
        logic [DEPTH_W-1:0]    lo;
        logic [DEPTH_W-1:0]    hi;
        logic [DEPTH_W-1:0]    tmp;
        logic [GAIN_W-1:0]     gain;
        logic [FSIZE_W-1:0]    fw;
        logic [FSIZE_W-1:0]    fh;
        int                    span;
        int                    n;
        int                    send_pcts[4];
        int                    stall_pcts[4];
        logic [DEPTH_W-1:0]    corner_depths[];

        send_pcts  = '{0, 68, 0, 35};
        stall_pcts = '{0, 0, 68, 35};
        win_min    = dwmb_pkg::MIN_DEPTH_RST;
        win_max    = dwmb_pkg::MAX_DEPTH_RST;
        win_gain   = dwmb_pkg::DISPLAY_GAIN_RST;
        win_width  = dwmb_pkg::FRAME_WIDTH_RST;
        win_height = dwmb_pkg::FRAME_HEIGHT_RST;
        clear_box();

        repeat (RST_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // reset window: both bounds and their neighbors, depth extremes
        @(posedge clk);
        corner_depths = '{16'd0, 16'd199, 16'd200, 16'd1000, 16'd1001, 16'hffff, 16'd600};
        foreach (corner_depths[i]) push_pixel(corner_depths[i]);
        wait_for_drain();

        // full window, top gain: saturation, and a narrower frame mid-row
        write_reg(dwmb_pkg::CFG_MIN_DEPTH, 24'd0);
        write_reg(dwmb_pkg::CFG_MAX_DEPTH, 24'd65535);
        write_reg(dwmb_pkg::CFG_DISPLAY_GAIN, 24'hffffff);
        write_reg(dwmb_pkg::CFG_FRAME_WIDTH, 24'd3);
        write_reg(dwmb_pkg::CFG_FRAME_HEIGHT, 24'd2);
        @(posedge clk);
        corner_depths = '{16'd0, 16'd1, 16'hffff, 16'h8000, 16'h7fff, 16'd5, 16'd0, 16'hffff};
        foreach (corner_depths[i]) push_pixel(corner_depths[i]);
        wait_for_drain();

        // empty window, zero gain, zero frame size: every pixel ends a frame, nothing found
        write_reg(dwmb_pkg::CFG_MIN_DEPTH, 24'd65535);
        write_reg(dwmb_pkg::CFG_MAX_DEPTH, 24'd0);
        write_reg(dwmb_pkg::CFG_DISPLAY_GAIN, 24'd0);
        write_reg(dwmb_pkg::CFG_FRAME_WIDTH, 24'd0);
        write_reg(dwmb_pkg::CFG_FRAME_HEIGHT, 24'd0);
        @(posedge clk);
        corner_depths = '{16'd0, 16'hffff, 16'd1000};
        foreach (corner_depths[i]) push_pixel(corner_depths[i]);
        wait_for_drain();

        // one-value window on a two-pixel frame
        write_reg(dwmb_pkg::CFG_MIN_DEPTH, 24'd500);
        write_reg(dwmb_pkg::CFG_MAX_DEPTH, 24'd500);
        write_reg(dwmb_pkg::CFG_DISPLAY_GAIN, 24'd1000);
        write_reg(dwmb_pkg::CFG_FRAME_WIDTH, 24'd2);
        @(posedge clk);
        corner_depths = '{16'd499, 16'd500, 16'd501, 16'd500};
        foreach (corner_depths[i]) push_pixel(corner_depths[i]);
        wait_for_drain();

        // random phases, two per idling pattern, fresh registers each time
        for (int p = 0; p < 8; p++) begin
            lo = DEPTH_W'($urandom_range(0, 40000));
            hi = lo + DEPTH_W'($urandom_range(0, 25535));
            case ($urandom_range(5))
                0: begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                1: lo = '0;
                2: hi = 16'hffff;
                default: ;
            endcase
            span = int'(hi) - int'(lo);
            // mostly the nominal reciprocal gain, sometimes anything
            if (span > 0 && $urandom_range(2) != 0)
                gain = GAIN_W'((32'd16711680 + span / 2) / span);
            else
                gain = GAIN_W'($urandom_range(0, 24'hffffff));
            case ($urandom_range(9))
                0:       fw = '0;
                1:       fw = 11'd1024;
                2:       fw = 11'd2047;
                default: fw = FSIZE_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(7))
                0:       fh = '0;
                1:       fh = 11'd2047;
                default: fh = FSIZE_W'($urandom_range(1, 6));
            endcase
            write_reg(dwmb_pkg::CFG_MIN_DEPTH, CFG_DATA_W'(lo));
            write_reg(dwmb_pkg::CFG_MAX_DEPTH, CFG_DATA_W'(hi));
            write_reg(dwmb_pkg::CFG_DISPLAY_GAIN, gain);
            write_reg(dwmb_pkg::CFG_FRAME_WIDTH, CFG_DATA_W'(fw));
            write_reg(dwmb_pkg::CFG_FRAME_HEIGHT, CFG_DATA_W'(fh));
            set_idling(send_pcts[p % 4], stall_pcts[p % 4]);
            n = $urandom_range(56, 74);
            @(posedge clk);
            repeat (n) push_pixel(pick_depth());
            if (p == 0) begin
                // receiver holds off while the sender keeps offering, so the block backs up
                @(posedge clk);
                hold_reqs++;
            end
            wait_for_drain();
        end

        if (error_count == 0) begin
            $display("tb_depth_window_mask_bbox passed");
        end else begin
            $display("tb_depth_window_mask_bbox failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * PERIOD);
        $display("tb_depth_window_mask_bbox failed");
        $finish;
    end

endmodule
